[rtl/lsi_pkg.sv]
// Lift safety interlock: shared types, mode and request codes, helper functions.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lsi_pkg;

  localparam int unsigned POS_W = 20;
  localparam int unsigned SPD_W = 16;
  localparam int unsigned MODE_W = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_JOY = 2'd1;
  localparam logic [1:0] REQ_GOTO = 2'd2;
  localparam logic [1:0] REQ_CLIMB = 2'd3;

  // lift modes
  localparam logic [MODE_W-1:0] M_NONE = 4'd0;
  localparam logic [MODE_W-1:0] M_MAN_NOM = 4'd1;
  localparam logic [MODE_W-1:0] M_MAN_ARM = 4'd2;
  localparam logic [MODE_W-1:0] M_MAN_BOT = 4'd3;
  localparam logic [MODE_W-1:0] M_MAN_MAX = 4'd4;
  localparam logic [MODE_W-1:0] M_PID_NOM = 4'd5;
  localparam logic [MODE_W-1:0] M_PID_ARM = 4'd6;
  localparam logic [MODE_W-1:0] M_PID_BRK_ARM = 4'd7;
  localparam logic [MODE_W-1:0] M_PID_BOT = 4'd8;
  localparam logic [MODE_W-1:0] M_PID_MAX = 4'd9;
  localparam logic [MODE_W-1:0] M_BRAKE = 4'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_MARGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_SAFE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_EPSILON = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_VEL_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSAL_FLAGS = 3'd6;

  // brake actuator codes
  localparam logic [1:0] BRAKE_ENGAGED = 2'd2;
  localparam logic [1:0] BRAKE_RELEASED = 2'd3;

  // 0.1 in Q1.14, rounded up
  localparam logic [16:0] DEADBAND = 17'd1639;
  localparam logic [14:0] SPEED_LIMIT_RST = 15'd16384;
  localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 20'sh80000;

  typedef struct packed {
    logic [1:0] req_type;
    logic signed [SPD_W-1:0] joystick_value;
    logic signed [POS_W-1:0] target_position;
    logic signed [POS_W-1:0] current_position;
    logic signed [SPD_W-1:0] current_velocity;
    logic bottom_switch;
    logic arm_safe;
    logic pid_stabilized;
  } lsi_in_t;

  typedef struct packed {
    logic motor_mode;
    logic signed [SPD_W-1:0] motor_speed;
    logic signed [POS_W-1:0] position_setpoint;
    logic [1:0] brake_code;
    logic [MODE_W-1:0] lift_mode;
    logic in_range;
    logic stabilized;
  } lsi_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0] max_height;
    logic signed [POS_W-1:0] hold_offset;
    logic signed [POS_W-1:0] arm_safe_height;
    logic [18:0] range_epsilon;
    logic [14:0] speed_limit;
    logic [14:0] brake_velocity_limit;
    logic [2:0] reversal_flags;
  } lsi_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic signed [POS_W-1:0] desired_position;
    logic signed [SPD_W-1:0] desired_speed;
    logic signed [SPD_W-1:0] raw_joystick;
    logic climb_latched;
    logic brake_engaged;
    logic held_mode;
    logic signed [SPD_W-1:0] held_speed;
    logic signed [POS_W-1:0] held_setpoint;
  } lsi_state_t;

  function automatic logic [16:0] abs17(input logic signed [SPD_W-1:0] v);
    logic signed [16:0] w;
    w = {v[SPD_W-1], v};
    return w[16] ? 17'(-w) : 17'(w);
  endfunction

  // a < b in sensor sign
  function automatic logic slt(input logic signed [POS_W-1:0] a,
                               input logic signed [POS_W-1:0] b,
                               input logic rev);
    return rev ? (a > b) : (a < b);
  endfunction

  function automatic logic spd_pos(input logic signed [SPD_W-1:0] v, input logic rev);
    return rev ? v[SPD_W-1] : (!v[SPD_W-1] && (v != '0));
  endfunction

  function automatic logic spd_neg(input logic signed [SPD_W-1:0] v, input logic rev);
    return rev ? (!v[SPD_W-1] && (v != '0)) : v[SPD_W-1];
  endfunction

  function automatic logic man_mode(input logic [MODE_W-1:0] m);
    return (m >= M_MAN_NOM) && (m <= M_MAN_MAX);
  endfunction

  function automatic logic is_pid(input logic [MODE_W-1:0] m);
    return (m >= M_PID_NOM) && (m <= M_PID_MAX);
  endfunction

  function automatic logic brake_mode(input logic [MODE_W-1:0] m);
    return (m == M_BRAKE) || (m == M_PID_BRK_ARM);
  endfunction

endpackage

`default_nettype wire

[rtl/lsi_cfg.sv]
// Lift safety interlock: configuration register file written over the cfg channel.
// Depends on lsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsi_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lsi_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lsi_pkg::lsi_cfg_t                     cfg
);
  import lsi_pkg::*;

  lsi_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_height <= '0;
      cfg_r.hold_offset <= '0;
      cfg_r.arm_safe_height <= '0;
      cfg_r.range_epsilon <= '0;
      cfg_r.speed_limit <= SPEED_LIMIT_RST;
      cfg_r.brake_velocity_limit <= '0;
      cfg_r.reversal_flags <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_HEIGHT:      cfg_r.max_height <= cfg_data;
        CFG_SAFETY_MARGIN:   cfg_r.hold_offset <= cfg_data;
        CFG_ARM_SAFE_HEIGHT: cfg_r.arm_safe_height <= cfg_data;
        CFG_RANGE_EPSILON:   cfg_r.range_epsilon <= cfg_data[18:0];
        CFG_SPEED_LIMIT:     cfg_r.speed_limit <= cfg_data[14:0];
        CFG_BRAKE_VEL_LIMIT: cfg_r.brake_velocity_limit <= cfg_data[14:0];
        CFG_REVERSAL_FLAGS:  cfg_r.reversal_flags <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/lsi_step.sv]
// Lift safety interlock: per-item next-state and result logic (combinational).
// Depends on lsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsi_step (
  input  wire lsi_pkg::lsi_cfg_t   cfg,
  input  wire lsi_pkg::lsi_state_t st,
  input  wire lsi_pkg::lsi_in_t    item,
  output lsi_pkg::lsi_state_t      st_nxt,
  output lsi_pkg::lsi_out_t        res
);
  import lsi_pkg::*;

  logic signed [POS_W:0]   hsum;
  logic signed [POS_W-1:0] hold_h;
  logic [16:0]             vel_abs;
  logic [16:0]             joy_abs;
  logic signed [16:0]      joy_x;
  logic signed [16:0]      lim_x;
  logic signed [16:0]      lim_neg;
  logic signed [SPD_W-1:0] joy_clamp;
  logic signed [POS_W:0]   err;
  logic [POS_W:0]          err_abs;
  logic                    vel_over;
  logic                    vel_under;
  logic                    rev_m;
  logic                    rev_s;
  logic signed [POS_W-1:0] cur;
  logic signed [SPD_W-1:0] dspd;
  logic signed [POS_W-1:0] dpos;
  logic signed [POS_W-1:0] maxh;
  logic signed [POS_W-1:0] ash;
  logic                    bot;
  logic                    arm;
  logic                    stab;

  assign rev_m = cfg.reversal_flags[0];
  assign rev_s = cfg.reversal_flags[1];
  assign cur = item.current_position;
  assign bot = item.bottom_switch;
  assign arm = item.arm_safe;
  assign stab = item.pid_stabilized;
  assign dspd = st.desired_speed;
  assign dpos = st.desired_position;
  assign maxh = cfg.max_height;
  assign ash = cfg.arm_safe_height;

  // hold height, saturated
  assign hsum = {ash[POS_W-1], ash} + {cfg.hold_offset[POS_W-1], cfg.hold_offset};
  assign hold_h = (hsum[POS_W] != hsum[POS_W-1]) ? (hsum[POS_W] ? POS_MIN : POS_MAX)
                                                   : hsum[POS_W-1:0];

  assign vel_abs = abs17(item.current_velocity);
  assign vel_over = vel_abs > {2'b00, cfg.brake_velocity_limit};
  assign vel_under = vel_abs < {2'b00, cfg.brake_velocity_limit};

  // joystick clamp
  assign joy_abs = abs17(item.joystick_value);
  assign joy_x = {item.joystick_value[SPD_W-1], item.joystick_value};
  assign lim_x = {2'b00, cfg.speed_limit};
  assign lim_neg = -lim_x;
  always_comb begin
    if (joy_x >= lim_x) begin
      joy_clamp = lim_x[SPD_W-1:0];
    end else if (joy_x <= lim_neg) begin
      joy_clamp = lim_neg[SPD_W-1:0];
    end else begin
      joy_clamp = item.joystick_value;
    end
  end

  always_comb begin
    st_nxt = st;
    unique case (item.req_type)
      REQ_TICK: begin
        if (st.climb_latched) begin
          st_nxt.held_mode = 1'b0;
          st_nxt.held_speed = st.raw_joystick;
          st_nxt.brake_engaged = 1'b0;
        end else begin
          if (!brake_mode(st.mode)) st_nxt.brake_engaged = 1'b0;
          unique case (st.mode)
            M_MAN_NOM: begin
              st_nxt.held_mode = 1'b0;
              st_nxt.held_speed = dspd;
              if (bot && spd_neg(dspd, rev_m)) begin
                st_nxt.held_speed = '0;
                st_nxt.mode = M_MAN_BOT;
              end else if (slt(cur, ash, rev_s) && !arm) begin
                st_nxt.held_mode = 1'b1;
                st_nxt.held_setpoint = hold_h;
                st_nxt.mode = M_MAN_ARM;
              end else if (slt(maxh, cur, rev_s) && spd_pos(dspd, rev_m)) begin
                st_nxt.held_mode = 1'b1;
                st_nxt.held_setpoint = maxh;
                st_nxt.mode = M_MAN_MAX;
              end
            end
            M_MAN_ARM: begin
              st_nxt.held_mode = 1'b1;
              st_nxt.held_setpoint = hold_h;
              if (spd_pos(dspd, rev_m) || arm) begin
                st_nxt.held_mode = 1'b0;
                st_nxt.held_speed = dspd;
                st_nxt.mode = M_MAN_NOM;
              end
            end
            M_MAN_BOT: begin
              st_nxt.held_mode = 1'b0;
              st_nxt.held_speed = '0;
              if (spd_pos(dspd, rev_m) || !bot) begin
                st_nxt.held_speed = dspd;
                st_nxt.mode = M_MAN_NOM;
              end
            end
            M_MAN_MAX: begin
              st_nxt.held_mode = 1'b1;
              st_nxt.held_setpoint = maxh;
              if (spd_neg(dspd, rev_m) || slt(cur, maxh, rev_s)) begin
                st_nxt.held_mode = 1'b0;
                st_nxt.held_speed = dspd;
                st_nxt.mode = M_MAN_NOM;
              end
            end
            M_PID_NOM: begin
              st_nxt.held_mode = 1'b1;
              st_nxt.held_setpoint = dpos;
              if (bot && slt(dpos, cur, rev_s)) begin
                st_nxt.held_mode = 1'b0;
                st_nxt.held_speed = '0;
                st_nxt.mode = M_PID_BOT;
              end else if (slt(dpos, ash, rev_s) && !arm) begin
                st_nxt.held_setpoint = hold_h;
                st_nxt.mode = M_PID_ARM;
              end else if (slt(maxh, dpos, rev_s)) begin
                st_nxt.held_setpoint = maxh;
                st_nxt.mode = M_PID_MAX;
              end
            end
            M_PID_ARM: begin
              st_nxt.held_mode = 1'b1;
              st_nxt.held_setpoint = hold_h;
              if (slt(ash, dpos, rev_s) || arm) begin
                st_nxt.held_setpoint = dpos;
                st_nxt.mode = M_PID_NOM;
              end
            end
            M_PID_BOT: begin
              st_nxt.held_mode = 1'b0;
              st_nxt.held_speed = '0;
              if (slt(cur, dpos, rev_s) || !bot) begin
                st_nxt.held_mode = 1'b1;
                st_nxt.held_setpoint = dpos;
                st_nxt.mode = M_PID_NOM;
              end
            end
            M_PID_MAX: begin
              st_nxt.held_mode = 1'b0;
              st_nxt.held_speed = '0;
              if (slt(dpos, cur, rev_s) || slt(cur, maxh, rev_s)) begin
                st_nxt.held_mode = 1'b1;
                st_nxt.held_setpoint = dpos;
                st_nxt.mode = M_PID_NOM;
              end
            end
            M_PID_BRK_ARM: begin
              st_nxt.held_mode = 1'b0;
              st_nxt.held_speed = '0;
              st_nxt.brake_engaged = !vel_over;
              if (slt(ash, dpos, rev_s) || arm) begin
                st_nxt.held_setpoint = dpos;
                st_nxt.mode = M_PID_NOM;
              end
            end
            M_BRAKE: begin
              st_nxt.held_mode = 1'b0;
              st_nxt.held_speed = '0;
              st_nxt.brake_engaged = !vel_over;
            end
            default: begin
              st_nxt.held_mode = 1'b0;
              st_nxt.held_speed = '0;
            end
          endcase
          // settled position loop drops onto the brake
          if (st_nxt.held_mode) begin
            if (vel_under) st_nxt.brake_engaged = stab;
            if (stab) begin
              st_nxt.held_mode = 1'b0;
              st_nxt.held_speed = '0;
              st_nxt.mode = (st.mode != M_PID_ARM) ? M_BRAKE : M_PID_BRK_ARM;
            end
          end
        end
      end
      REQ_JOY: begin
        st_nxt.raw_joystick = item.joystick_value;
        if (joy_abs >= DEADBAND) begin
          st_nxt.desired_speed = joy_clamp;
          if (!man_mode(st.mode)) st_nxt.mode = M_MAN_NOM;
        end else if (!is_pid(st.mode)) begin
          st_nxt.mode = M_PID_NOM;
          st_nxt.desired_position = cur;
        end
      end
      REQ_GOTO: begin
        if (!is_pid(st.mode)) st_nxt.mode = M_PID_NOM;
        st_nxt.desired_position = item.target_position;
      end
      REQ_CLIMB: begin
        st_nxt.climb_latched = 1'b1;
      end
      default: ;
    endcase
  end

  assign err = {cur[POS_W-1], cur} - {st_nxt.desired_position[POS_W-1], st_nxt.desired_position};
  assign err_abs = err[POS_W] ? (POS_W+1)'(-err) : (POS_W+1)'(err);

  always_comb begin
    res.motor_mode = st_nxt.held_mode;
    res.motor_speed = st_nxt.held_speed;
    res.position_setpoint = st_nxt.held_setpoint;
    res.brake_code = (st_nxt.brake_engaged ^ cfg.reversal_flags[2]) ? BRAKE_ENGAGED
                                                                     : BRAKE_RELEASED;
    res.lift_mode = st_nxt.mode;
    res.in_range = (is_pid(st_nxt.mode) && (err_abs < {2'b00, cfg.range_epsilon}))
                   || brake_mode(st_nxt.mode);
    res.stabilized = (st_nxt.mode == M_BRAKE);
  end

endmodule

`default_nettype wire

[rtl/lift_safety_interlock_fsm.sv]
// Lift safety interlock, top level: input register, step logic, state and result registers.
// Path: an item is registered in the input register, then goes through the step logic into the result register.
// Throughput: one item per cycle unless out_ready stalls the result register; that stall also holds the input register.
// Reset (synchronous, rst_n low): mode brake applied, brake engaged, all held values zero,
// both pipeline stages empty, configuration registers at their documented defaults.
// Depends on lsi_pkg, lsi_cfg, lsi_step.
`timescale 1ns / 1ps
`default_nettype none

module lift_safety_interlock_fsm (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lsi_pkg::lsi_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lsi_pkg::lsi_out_t                     out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lsi_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lsi_pkg::*;

  lsi_cfg_t   cfg;
  lsi_in_t    in_r;
  logic       in_valid_r;
  lsi_state_t st_r;
  lsi_state_t st_nxt;
  lsi_out_t   res;
  lsi_out_t   out_r;
  logic       out_valid_r;
  logic       advance;

  lsi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsi_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign advance = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode <= M_BRAKE;
      st_r.desired_position <= '0;
      st_r.desired_speed <= '0;
      st_r.raw_joystick <= '0;
      st_r.climb_latched <= 1'b0;
      st_r.brake_engaged <= 1'b1;
      st_r.held_mode <= 1'b0;
      st_r.held_speed <= '0;
      st_r.held_setpoint <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/lsi_checker.sv]
// Lift safety interlock: port-level assertion checker and its bind to the top level.
// Depends on lsi_pkg and lift_safety_interlock_fsm.
`timescale 1ns / 1ps
`default_nettype none

module lsi_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire lsi_pkg::lsi_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire lsi_pkg::lsi_out_t out_data
);
  import lsi_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

  a_brake_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.brake_code == BRAKE_ENGAGED ||
                   out_data.brake_code == BRAKE_RELEASED))
    else $error("bad brake code");

  a_stab_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.stabilized == (out_data.lift_mode == M_BRAKE)))
    else $error("stabilized flag disagrees with mode");

  a_brake_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.lift_mode == M_BRAKE || out_data.lift_mode == M_PID_BRK_ARM)
    |-> out_data.in_range && !out_data.motor_mode)
    else $error("brake mode without in-range or with position drive");

endmodule

bind lift_safety_interlock_fsm lsi_checker u_lsi_checker (.*);

`default_nettype wire
